>>> rtl/adpcm_npd_pkg.sv
// Types, constants and per-nibble decode functions for the ADPCM nibble pair decoder.
package adpcm_npd_pkg;

  localparam int SAMPLE_W   = 8;
  localparam int INDEX_W    = 7;
  localparam int STEP_W     = 15;
  localparam int CODE_W     = 4;
  localparam int PROD_W     = STEP_W + 3;
  localparam int MAG_W      = STEP_W + 2;
  localparam int SUM_W      = MAG_W + 2;

  localparam logic [INDEX_W-1:0]  MAX_STEP_INDEX = 7'd88;
  localparam logic signed [SUM_W-1:0] SUM_MAX = 19'sd127;
  localparam logic signed [SUM_W-1:0] SUM_MIN = -19'sd128;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 8'sd127;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = -8'sd128;

  typedef logic [CODE_W-1:0]         code_t;
  typedef logic [INDEX_W-1:0]        index_t;
  typedef logic [STEP_W-1:0]         step_t;
  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // Decoder state after one nibble.
  typedef struct packed {
    sample_t predictor;
    index_t  step_index;
  } dec_state_t;

  // Step size table; an index above the top reads as the top entry.
  function automatic step_t step_lookup(input index_t idx);
    step_t s;
    unique case (idx)
      7'd0:  s = 15'd7;     7'd1:  s = 15'd8;     7'd2:  s = 15'd9;
      7'd3:  s = 15'd10;    7'd4:  s = 15'd11;    7'd5:  s = 15'd12;
      7'd6:  s = 15'd13;    7'd7:  s = 15'd14;    7'd8:  s = 15'd16;
      7'd9:  s = 15'd17;    7'd10: s = 15'd19;    7'd11: s = 15'd21;
      7'd12: s = 15'd23;    7'd13: s = 15'd25;    7'd14: s = 15'd28;
      7'd15: s = 15'd31;    7'd16: s = 15'd34;    7'd17: s = 15'd37;
      7'd18: s = 15'd41;    7'd19: s = 15'd45;    7'd20: s = 15'd50;
      7'd21: s = 15'd55;    7'd22: s = 15'd60;    7'd23: s = 15'd66;
      7'd24: s = 15'd73;    7'd25: s = 15'd80;    7'd26: s = 15'd88;
      7'd27: s = 15'd97;    7'd28: s = 15'd107;   7'd29: s = 15'd118;
      7'd30: s = 15'd130;   7'd31: s = 15'd143;   7'd32: s = 15'd157;
      7'd33: s = 15'd173;   7'd34: s = 15'd190;   7'd35: s = 15'd209;
      7'd36: s = 15'd230;   7'd37: s = 15'd253;   7'd38: s = 15'd279;
      7'd39: s = 15'd307;   7'd40: s = 15'd337;   7'd41: s = 15'd371;
      7'd42: s = 15'd408;   7'd43: s = 15'd449;   7'd44: s = 15'd494;
      7'd45: s = 15'd544;   7'd46: s = 15'd598;   7'd47: s = 15'd658;
      7'd48: s = 15'd724;   7'd49: s = 15'd796;   7'd50: s = 15'd876;
      7'd51: s = 15'd963;   7'd52: s = 15'd1060;  7'd53: s = 15'd1166;
      7'd54: s = 15'd1282;  7'd55: s = 15'd1411;  7'd56: s = 15'd1552;
      7'd57: s = 15'd1707;  7'd58: s = 15'd1878;  7'd59: s = 15'd2066;
      7'd60: s = 15'd2272;  7'd61: s = 15'd2499;  7'd62: s = 15'd2749;
      7'd63: s = 15'd3024;  7'd64: s = 15'd3327;  7'd65: s = 15'd3660;
      7'd66: s = 15'd4026;  7'd67: s = 15'd4428;  7'd68: s = 15'd4871;
      7'd69: s = 15'd5358;  7'd70: s = 15'd5894;  7'd71: s = 15'd6484;
      7'd72: s = 15'd7132;  7'd73: s = 15'd7845;  7'd74: s = 15'd8630;
      7'd75: s = 15'd9493;  7'd76: s = 15'd10442; 7'd77: s = 15'd11487;
      7'd78: s = 15'd12635; 7'd79: s = 15'd13899; 7'd80: s = 15'd15289;
      7'd81: s = 15'd16818; 7'd82: s = 15'd18500; 7'd83: s = 15'd20350;
      7'd84: s = 15'd22385; 7'd85: s = 15'd24623; 7'd86: s = 15'd27086;
      7'd87: s = 15'd29794;
      default: s = 15'd32767;
    endcase
    return s;
  endfunction

  // Move and clamp the step index by the code's magnitude bits.
  function automatic index_t index_update(input index_t idx, input code_t code);
    logic signed [INDEX_W+1:0] adj;
    logic signed [INDEX_W+1:0] nxt;
    unique case (code[2:0])
      3'd4:    adj = 9'sd2;
      3'd5:    adj = 9'sd4;
      3'd6:    adj = 9'sd6;
      3'd7:    adj = 9'sd8;
      default: adj = -9'sd1;
    endcase
    nxt = $signed({2'b00, idx}) + adj;
    if (nxt < 0) begin
      return '0;
    end else if (nxt > $signed({2'b00, MAX_STEP_INDEX})) begin
      return MAX_STEP_INDEX;
    end
    return nxt[INDEX_W-1:0];
  endfunction

  // Decode one nibble against the current state.
  function automatic dec_state_t decode_nibble(input dec_state_t cur, input code_t code);
    step_t                   step;
    index_t                  idx;
    logic [PROD_W-1:0]       prod;
    logic [MAG_W-1:0]        mag;
    logic signed [SUM_W-1:0] diff;
    logic signed [SUM_W-1:0] sum;
    dec_state_t              res;
    idx  = (cur.step_index > MAX_STEP_INDEX) ? MAX_STEP_INDEX : cur.step_index;
    step = step_lookup(idx);
    prod = PROD_W'(step) * PROD_W'(code[2:0]);
    mag  = MAG_W'(prod[PROD_W-1:2]) + MAG_W'(step[STEP_W-1:3]);
    diff = $signed({2'b00, mag});
    if (code[3]) begin
      diff = -diff;
    end
    sum = SUM_W'(cur.predictor) + diff;
    if (sum > SUM_MAX) begin
      res.predictor = SAMPLE_MAX;
    end else if (sum < SUM_MIN) begin
      res.predictor = SAMPLE_MIN;
    end else begin
      res.predictor = sum[SAMPLE_W-1:0];
    end
    res.step_index = index_update(idx, code);
    return res;
  endfunction

endpackage

>>> rtl/adpcm_nibble_pair_decoder_top.sv
// Top level of the ADPCM nibble pair decoder: two chained nibble decodes per byte.
// The result item is registered at the edge that accepts the byte.
// Throughput: one byte per cycle while in_stall is low; both nibble steps and
//   table lookups sit between the decoder state registers and the result register.
// The result register frees itself in the cycle its item is taken, so a new byte
//   is accepted while a result is read out.
// Reset (rst, synchronous, active high) clears predictor, step index and out_valid.
module adpcm_nibble_pair_decoder_top
  import adpcm_npd_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [7:0]    code_byte,
  input  logic          restart,
  output logic          out_valid,
  input  logic          out_stall,
  output sample_t       first_sample,
  output sample_t       second_sample
);

  dec_state_t state;
  dec_state_t start_state;
  dec_state_t mid_state;
  dec_state_t state_next;
  logic       in_accept;

  // Hold input while an unread result blocks the result register.
  assign in_stall  = out_valid & out_stall;
  assign in_accept = in_valid & ~in_stall;

  // Decode high nibble, then low nibble; restart first clears the step index.
  always_comb begin
    start_state = state;
    if (restart) begin
      start_state.step_index = '0;
    end
    mid_state  = decode_nibble(start_state, code_byte[7:4]);
    state_next = decode_nibble(mid_state, code_byte[3:0]);
  end

  // Advance decoder state on each accepted item.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (in_accept) begin
      state <= state_next;
    end
  end

  // Track result valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Load result payload.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      first_sample  <= mid_state.predictor;
      second_sample <= state_next.predictor;
    end
  end

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    state.step_index <= MAX_STEP_INDEX)
    else $error("step index beyond table");

  a_accept_valid: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> out_valid)
    else $error("accepted item produced no result");

  a_pred_match: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (second_sample == state.predictor))
    else $error("result out of step with predictor");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with empty result register");

endmodule
